[src/clas_pkg.sv]
// Shared types and byte codes for the command line argument splitter.
// No dependencies; compile first.
`default_nettype none
package clas_pkg;

  localparam int unsigned PEND_W = 6;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic              in_word;
    logic              in_quotes;
    logic [PEND_W-1:0] pend;
  } parse_state_t;

  // What one input byte asks the emitter to send
  typedef struct packed {
    logic [PEND_W-1:0] bs_cnt;     // backslashes to send first
    logic              tail_en;    // one more result after them
    logic              tail_bv;    // byte_valid of that result
    logic [7:0]        tail_byte;
    logic              end_word;   // last result carries arg_end
  } emit_plan_t;

endpackage
`default_nettype wire

[src/clas_if.sv]
// Valid/ready channel interfaces for the argument splitter.
// Depends on nothing; compile after clas_pkg.
`default_nettype none
interface clas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;
  modport source (output valid, ch, line_end, input ready);
  modport sink   (input valid, ch, line_end, output ready);
endinterface

interface clas_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       arg_end;
  logic       last_of_run;
  modport source (output valid, byte_valid, out_byte, arg_end, last_of_run, input ready);
  modport sink   (input valid, byte_valid, out_byte, arg_end, last_of_run, output ready);
endinterface
`default_nettype wire

[src/clas_decode.sv]
// Byte classifier: turns one input byte and the parser state into an emit plan
// and the next parser state. Depends on clas_pkg.
`default_nettype none
module clas_decode import clas_pkg::*; #(
  parameter int unsigned MAX_BACKSLASH_RUN = 60
) (
  input  wire logic [7:0]   ch,
  input  wire logic         line_end,
  input  wire parse_state_t st,
  output emit_plan_t        plan,
  output parse_state_t      st_nxt
);

  localparam logic [PEND_W-1:0] MaxRun = PEND_W'(MAX_BACKSLASH_RUN);

  always_comb begin
    logic end_w;
    end_w  = 1'b0;
    st_nxt = st;
    plan   = '0;

    // Classify the byte
    if (ch == CH_BSLASH) begin
      st_nxt.in_word = 1'b1;
      if (st.pend < MaxRun) begin
        st_nxt.pend = st.pend + 1'b1;
      end
      if (line_end) begin
        plan.bs_cnt = st_nxt.pend;
      end
    end else if (ch == CH_DQUOTE) begin
      st_nxt.in_word = 1'b1;
      plan.bs_cnt    = st.pend >> 1;
      if (st.pend[0]) begin
        plan.tail_en   = 1'b1;
        plan.tail_bv   = 1'b1;
        plan.tail_byte = CH_DQUOTE;
      end else begin
        st_nxt.in_quotes = ~st.in_quotes;
      end
      st_nxt.pend = '0;
    end else if ((ch == CH_SPACE || ch == CH_TAB) && !st.in_quotes) begin
      if (st.in_word) begin
        plan.bs_cnt = st.pend;
        end_w       = 1'b1;
      end
      st_nxt.pend = '0;
    end else begin
      st_nxt.in_word = 1'b1;
      plan.bs_cnt    = st.pend;
      plan.tail_en   = 1'b1;
      plan.tail_bv   = 1'b1;
      plan.tail_byte = ch;
      st_nxt.pend    = '0;
    end

    if (line_end && st_nxt.in_word) begin
      end_w = 1'b1;
    end

    // Close the word; add an empty marker result when nothing carries the mark
    if (end_w) begin
      if (plan.bs_cnt == '0 && !plan.tail_en) begin
        plan.tail_en   = 1'b1;
        plan.tail_bv   = 1'b0;
        plan.tail_byte = '0;
      end
      st_nxt = '0;
    end
    plan.end_word = end_w;

    if (line_end) begin
      st_nxt = '0;
    end
  end

endmodule
`default_nettype wire

[src/command_line_argument_splitter_unit.sv]
// Top level of the command line argument splitter: handshake, emit sequencer
// and output register. Depends on clas_pkg, clas_if and clas_decode.
//
// Takes a command line one byte per transfer and returns argument bytes with
// end-of-argument marks. The sequencer takes a byte while idle, then sends its
// results from the emit down-counter, one result per cycle while the output
// slot is free; a byte with no result leaves the sequencer idle. A held run
// of up to MAX_BACKSLASH_RUN backslashes is sent by that counter, one
// backslash a cycle while the slot is free. in_if.ready is high only
// while the sequencer is idle; the output register may still hold a result.
`default_nettype none
module command_line_argument_splitter_unit import clas_pkg::*; #(
  parameter int unsigned MAX_BACKSLASH_RUN = 60
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  clas_in_if.sink     in_if,
  clas_out_if.source  out_if
);

  typedef enum logic {S_IDLE, S_EMIT} seq_state_t;

  seq_state_t   state_r;
  parse_state_t pst_r;
  parse_state_t pst_nxt;
  emit_plan_t   plan;
  emit_plan_t   plan_r;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_bv_r;
  logic [7:0] out_byte_r;
  logic       out_end_r;
  logic       out_last_r;

  logic in_xfer;
  logic slot_free;
  logic bs_left;
  logic last_now;

  clas_decode #(
    .MAX_BACKSLASH_RUN(MAX_BACKSLASH_RUN)
  ) u_decode (
    .ch       (in_if.ch),
    .line_end (in_if.line_end),
    .st       (pst_r),
    .plan     (plan),
    .st_nxt   (pst_nxt)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign slot_free   = !out_valid_r || out_if.ready;
  assign bs_left     = (plan_r.bs_cnt != '0);
  assign last_now    = bs_left ? (plan_r.bs_cnt == PEND_W'(1) && !plan_r.tail_en) : 1'b1;

  // Load a new result when emitting into a free slot, otherwise drop the one just taken
  assign out_valid_nxt = (state_r == S_EMIT && slot_free) ? 1'b1
                                                          : (out_valid_r && !out_if.ready);

  // Sequencer, parser state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pst_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            pst_r  <= pst_nxt;
            plan_r <= plan;
            if (plan.bs_cnt != '0 || plan.tail_en) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          // Advance one result whenever the output slot frees up
          if (slot_free) begin
            out_last_r  <= last_now;
            out_end_r   <= last_now && plan_r.end_word;
            if (bs_left) begin
              out_bv_r      <= 1'b1;
              out_byte_r    <= CH_BSLASH;
              plan_r.bs_cnt <= plan_r.bs_cnt - 1'b1;
            end else begin
              out_bv_r   <= plan_r.tail_bv;
              out_byte_r <= plan_r.tail_byte;
            end
            if (last_now) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.byte_valid  = out_bv_r;
  assign out_if.out_byte    = out_byte_r;
  assign out_if.arg_end     = out_end_r;
  assign out_if.last_of_run = out_last_r;

endmodule
`default_nettype wire

[src/clas_checker.sv]
// Port-level checks for the argument splitter, bound to the top level.
// Depends on command_line_argument_splitter_unit.
`default_nettype none
module clas_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       byte_valid,
  input wire logic [7:0] out_byte,
  input wire logic       arg_end,
  input wire logic       last_of_run
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(arg_end) && $stable(last_of_run))
    else $error("result changed while stalled");

  // An empty marker carries a zero byte
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> out_byte == 8'h00)
    else $error("empty marker with nonzero byte");

  // An empty marker exists only to close a word and is alone in its run
  a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> arg_end && last_of_run)
    else $error("empty marker without word end");

  // The word mark sits on the final result of a byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && arg_end |-> last_of_run)
    else $error("arg_end before end of run");

endmodule

bind command_line_argument_splitter_unit clas_checker u_clas_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .byte_valid  (out_if.byte_valid),
  .out_byte    (out_if.out_byte),
  .arg_end     (out_if.arg_end),
  .last_of_run (out_if.last_of_run)
);
`default_nettype wire

[dv/testbench.sv]
// Testbench for command_line_argument_splitter_unit: byte-level argument
// splitting checked against a cycle-free predictor. Depends on clas_pkg,
// clas_if and the RTL under src.
`timescale 1ns / 1ps
module testbench;
  import clas_pkg::*;

  localparam int MAX_BS       = 60;
  localparam int MAX_RESULTS  = 62;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       arg_end;
    logic       last_of_run;
  } arg_result_t;

  typedef logic [7:0] cmd_line_t[$];

  logic clk;
  logic rst_n;

  clas_in_if  in_ch ();
  clas_out_if out_ch ();

  command_line_argument_splitter_unit #(
    .MAX_BACKSLASH_RUN(MAX_BS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Splitter state as the predictor sees it
  logic        word_open;
  logic        quoted;
  int unsigned held_bs;

  arg_result_t expected_arg_bytes[$];

  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int hold_served   = 0;

  int items_sent    = 0;
  int results_seen  = 0;
  int args_closed   = 0;
  int fail_count    = 0;
  int shown_fails   = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the results of one accepted byte and queue them
  function automatic void split_step(input logic [7:0] c, input logic le);
    arg_result_t run[$];
    arg_result_t r;
    bit          end_word;
    int unsigned n;
    end_word = 0;
    if (c == CH_BSLASH) begin
      word_open = 1'b1;
      if (held_bs < MAX_BS) held_bs++;
      if (le) begin
        repeat (held_bs) run.push_back('{1'b1, CH_BSLASH, 1'b0, 1'b0});
        held_bs = 0;
      end
    end else if (c == CH_DQUOTE) begin
      word_open = 1'b1;
      repeat (held_bs / 2) run.push_back('{1'b1, CH_BSLASH, 1'b0, 1'b0});
      if (held_bs % 2 == 1) run.push_back('{1'b1, CH_DQUOTE, 1'b0, 1'b0});
      else quoted = ~quoted;
      held_bs = 0;
    end else if ((c == CH_SPACE || c == CH_TAB) && !quoted) begin
      if (word_open) begin
        repeat (held_bs) run.push_back('{1'b1, CH_BSLASH, 1'b0, 1'b0});
        end_word = 1;
      end
      held_bs = 0;
    end else begin
      word_open = 1'b1;
      repeat (held_bs) run.push_back('{1'b1, CH_BSLASH, 1'b0, 1'b0});
      held_bs = 0;
      run.push_back('{1'b1, c, 1'b0, 1'b0});
    end

    if (le && word_open) end_word = 1;

    // Close the word, with an empty result when no byte can carry the mark
    if (end_word) begin
      if (run.size() == 0) run.push_back('{1'b0, 8'h00, 1'b0, 1'b0});
      n = run.size();
      r = run[n-1];
      r.arg_end = 1'b1;
      run[n-1] = r;
      word_open = 1'b0;
      quoted    = 1'b0;
      held_bs   = 0;
    end

    if (le) begin
      word_open = 1'b0;
      quoted    = 1'b0;
      held_bs   = 0;
    end

    n = run.size();
    if (n > 0) begin
      r = run[n-1];
      r.last_of_run = 1'b1;
      run[n-1] = r;
    end
    foreach (run[i]) expected_arg_bytes.push_back(run[i]);
  endfunction

  // Offer one byte, with random idle cycles first, and hold it until transfer
  task automatic send_byte(input logic [7:0] c, input logic le);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.ch       <= c;
    in_ch.line_end <= le;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    split_step(c, le);
    items_sent++;
  endtask

  task automatic send_line(input cmd_line_t l);
    foreach (l[i]) send_byte(l[i], i == l.size() - 1);
  endtask

  function automatic cmd_line_t text_bytes(input string s);
    cmd_line_t l;
    for (int i = 0; i < s.len(); i++) l.push_back(s[i]);
    return l;
  endfunction

  // Mostly well-formed words with quotes and backslash runs; some pure noise
  function automatic cmd_line_t random_line();
    cmd_line_t l;
    int        len;
    int        pick;
    int        run;
    bit        noise;
    len   = $urandom_range(12, 1);
    noise = ($urandom_range(9) == 0);
    while (l.size() < len) begin
      pick = noise ? 99 : $urandom_range(99);
      if (pick < 35) begin
        l.push_back(8'($urandom_range(8'h7E, 8'h21)));
      end else if (pick < 50) begin
        l.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
      end else if (pick < 62) begin
        l.push_back(CH_DQUOTE);
      end else if (pick < 80) begin
        run = ($urandom_range(39) == 0) ? $urandom_range(63, 55) : $urandom_range(4, 1);
        repeat (run) l.push_back(CH_BSLASH);
      end else begin
        l.push_back(8'($urandom_range(255)));
      end
    end
    return l;
  endfunction

  // Drop valid and hold off until every queued result has come back
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_arg_bytes.size() != 0);
  endtask

  task automatic test_directed();
    send_line(text_bytes(" a\tb "));
    send_line(text_bytes("\"x y\""));
    send_line(text_bytes("\\\\\""));
    send_line(text_bytes("\\\\\\\""));
    send_line(text_bytes("\\\\ z"));
    send_line(text_bytes("\"\""));
    send_line('{8'h00, 8'hFF, CH_BSLASH});
    wait_for_drain();
  endtask

  // Saturate the held count, then flush it before an ordinary byte and a quote
  task automatic test_long_backslash_run();
    cmd_line_t l;
    repeat (MAX_BS + 3) l.push_back(CH_BSLASH);
    l.push_back(8'h41);
    send_line(l);
    l.delete();
    repeat (MAX_BS + 1) l.push_back(CH_BSLASH);
    l.push_back(CH_DQUOTE);
    l.push_back(8'h42);
    send_line(l);
    wait_for_drain();
  endtask

  // Stall the receiver for a long stretch while bytes keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    rx_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (4) send_line(random_line());
    wait_for_drain();
  endtask

  task automatic test_random_lines(input int idle_pct, input int stall_pct,
                                   input int n_items);
    int start;
    start         = items_sent;
    send_idle_pct = idle_pct;
    rx_stall_pct <= stall_pct;
    while (items_sent - start < n_items) send_line(random_line());
    wait_for_drain();
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    arg_result_t got;
    arg_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.byte_valid, out_ch.out_byte, out_ch.arg_end, out_ch.last_of_run};
      results_seen++;
      if (got.arg_end === 1'b1) args_closed++;
      if (expected_arg_bytes.size() == 0) begin
        fail_count++;
        if (shown_fails < SHOW_LIMIT) begin
          shown_fails++;
          $display("[%0t] unexpected result: bv=%b byte=%h end=%b last=%b", $realtime,
                   got.byte_valid, got.out_byte, got.arg_end, got.last_of_run);
        end
      end else begin
        exp_r = expected_arg_bytes.pop_front();
        if (got.byte_valid !== exp_r.byte_valid || got.out_byte !== exp_r.out_byte ||
            got.arg_end !== exp_r.arg_end || got.last_of_run !== exp_r.last_of_run) begin
          fail_count++;
          if (shown_fails < SHOW_LIMIT) begin
            shown_fails++;
            $display({"[%0t] mismatch: expected bv=%b byte=%h end=%b last=%b,",
                      " got bv=%b byte=%h end=%b last=%b"},
                     $realtime, exp_r.byte_valid, exp_r.out_byte, exp_r.arg_end,
                     exp_r.last_of_run, got.byte_valid, got.out_byte, got.arg_end,
                     got.last_of_run);
          end
        end
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles, %0d results outstanding", QUIET_LIMIT,
             expected_arg_bytes.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main
    word_open = 1'b0;
    quoted    = 1'b0;
    held_bs   = 0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.ch       <= 8'h00;
    in_ch.line_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_long_backslash_run();
    test_backpressure();
    test_random_lines(0, 0, 70);
    test_random_lines(59, 0, 70);
    test_random_lines(0, 59, 70);
    test_random_lines(23, 23, 70);

    // Let any stray result show up before the verdict
    repeat (MAX_RESULTS + 16) @(posedge clk);
    if (expected_arg_bytes.size() != 0) fail_count += expected_arg_bytes.size();

    $display("Run covered %0d command line bytes, %0d results and %0d arguments,",
             items_sent, results_seen, args_closed);
    $display("with quoting, backslash runs up to saturation, stalls and a long hold-off.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/clas_pkg.sv
src/clas_if.sv
src/clas_decode.sv
src/command_line_argument_splitter_unit.sv
src/clas_checker.sv
dv/testbench.sv
